@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL that checks its own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low synchronous reset.
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication under an active-low synchronous reset.
`define ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/plo_pkg.sv @@
// Constants and register codes for the path length odometer.
package plo_pkg;

    localparam int SLOT_BITS  = 8;
    localparam int RATE_BITS  = 16;
    localparam int LIMIT_BITS = 26;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = LIMIT_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TRACKED_SLOT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_JUMP_LIMIT   = 2'd1;

    localparam logic [SLOT_BITS-1:0]  SLOT_RESET  = 8'd0;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 26'd256000;

    // Input tdata layout: owner, rate, then the three coordinates.
    localparam int OWNER_LSB = 0;
    localparam int RATE_LSB  = OWNER_LSB + SLOT_BITS;
    localparam int POS_LSB   = RATE_LSB + RATE_BITS;

    // Output tuser layout.
    localparam int USER_ADDED = 0;
    localparam int USER_JUMP  = 1;
    localparam int M_USER_BITS = 2;

endpackage

@@ rtl/core/path_length_odometer.sv @@
// Path length odometer: serial squares, serial square root, saturating total.
//
// Input requests arrive on s_tvalid/s_tready: s_tuser carries the restart flag,
// s_tdata carries owner, rate and the x/y/z position. Each request gives one
// result on m_tvalid/m_tready: m_tdata is the running total, m_tuser flags
// whether a segment was added or a jump restarted tracking.
// A request counts when owner matches tracked_slot and rate is non-zero.
// The first counted request only records its position; a start-only or
// uncounted request goes from ST_IDLE straight to ST_DONE.
// A measured request runs the three squares together, one multiplier bit per
// cycle in ST_MUL, then the square root, one root bit per cycle in ST_SQRT.
// One request is in work at a time; s_tready is high when the datapath is idle.
// The result sits in an output register, so the next request is accepted
// while the receiver stalls; a finished result waits there for m_tready.
// Configuration writes on cfg_valid/cfg_index/cfg_wdata are always accepted
// and must only be issued while the block is idle.
// aresetn (synchronous, active low) clears the total, the start flag, the last
// position and the registers to their reset values.
`include "assert_macros.svh"

module path_length_odometer
    import plo_pkg::*;
#(
    parameter int POS_BITS   = 24,
    parameter int TOTAL_BITS = 40
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // owner [7:0], rate, pos_x, pos_y, pos_z from bit 0 up, zero padded
    input  logic [((SLOT_BITS+RATE_BITS+3*POS_BITS+7)/8)*8-1:0] s_tdata,
    // restart
    input  logic                                   s_tuser,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // total_distance from bit 0 up, zero padded
    output logic [((TOTAL_BITS+7)/8)*8-1:0]        m_tdata,
    // added [0], jump_seen [1]
    output logic [M_USER_BITS-1:0]                 m_tuser,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
    input  logic [CFG_DATA_BITS-1:0]               cfg_wdata
);

    localparam int M_DATA_BITS = ((TOTAL_BITS + 7) / 8) * 8;
    localparam int ROOT_BITS   = POS_BITS + 1;
    localparam int SUM_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int ACC_BITS    = POS_BITS + 3;
    localparam int CNT_BITS    = $clog2(ROOT_BITS);
    localparam int CMP_BITS    = (ROOT_BITS > LIMIT_BITS) ? ROOT_BITS : LIMIT_BITS;
    localparam int ADD_BITS    = ((TOTAL_BITS > LIMIT_BITS) ? TOTAL_BITS : LIMIT_BITS) + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SQRT, ST_DONE} state_t;

    state_t                  state_reg, state_next;
    logic [SLOT_BITS-1:0]    slot_reg, slot_next;
    logic [LIMIT_BITS-1:0]   limit_reg, limit_next;
    logic                    have_last_reg, have_last_next;
    logic                    measure_reg, measure_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic [POS_BITS-1:0]     last_x_reg, last_x_next;
    logic [POS_BITS-1:0]     last_y_reg, last_y_next;
    logic [POS_BITS-1:0]     last_z_reg, last_z_next;
    logic [POS_BITS-1:0]     mag_x_reg, mag_x_next;
    logic [POS_BITS-1:0]     mag_y_reg, mag_y_next;
    logic [POS_BITS-1:0]     mag_z_reg, mag_z_next;
    logic [POS_BITS-1:0]     mul_x_reg, mul_x_next;
    logic [POS_BITS-1:0]     mul_y_reg, mul_y_next;
    logic [POS_BITS-1:0]     mul_z_reg, mul_z_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic [REM_BITS-1:0]     rem_reg, rem_next;
    logic [ROOT_BITS-1:0]    root_reg, root_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_BITS-1:0]  m_tdata_reg, m_tdata_next;
    logic [M_USER_BITS-1:0]  m_tuser_reg, m_tuser_next;

    logic [SLOT_BITS-1:0]    in_owner;
    logic [RATE_BITS-1:0]    in_rate;
    logic [POS_BITS-1:0]     in_x, in_y, in_z;
    logic                    counted;
    logic                    hl_eff;
    logic [TOTAL_BITS-1:0]   total_eff;
    logic [ACC_BITS-1:0]     acc;
    logic [REM_BITS-1:0]     rem_sh, trial;
    logic [CMP_BITS-1:0]     dist_w, limit_w;
    logic [ADD_BITS-1:0]     add_sum;
    logic [TOTAL_BITS-1:0]   total_sat;
    logic                    out_free;

    function automatic logic [POS_BITS-1:0] abs_diff(
        input logic [POS_BITS-1:0] a,
        input logic [POS_BITS-1:0] b
    );
        logic [POS_BITS:0] d;
        d = {a[POS_BITS-1], a} - {b[POS_BITS-1], b};
        if (d[POS_BITS]) begin
            d = ~d + 1'b1;
        end
        return d[POS_BITS-1:0];
    endfunction

    assign in_owner = s_tdata[OWNER_LSB +: SLOT_BITS];
    assign in_rate  = s_tdata[RATE_LSB +: RATE_BITS];
    assign in_x     = s_tdata[POS_LSB +: POS_BITS];
    assign in_y     = s_tdata[POS_LSB + POS_BITS +: POS_BITS];
    assign in_z     = s_tdata[POS_LSB + 2*POS_BITS +: POS_BITS];

    assign counted   = (in_owner == slot_reg) && (in_rate != '0);
    assign hl_eff    = s_tuser ? 1'b0 : have_last_reg;
    assign total_eff = s_tuser ? '0 : total_reg;

    // Three partial products share one narrow adder with the upper sum half.
    assign acc = ACC_BITS'(sum_reg[SUM_BITS-1:POS_BITS])
               + (mul_x_reg[0] ? ACC_BITS'(mag_x_reg) : '0)
               + (mul_y_reg[0] ? ACC_BITS'(mag_y_reg) : '0)
               + (mul_z_reg[0] ? ACC_BITS'(mag_z_reg) : '0);

    // One root bit per cycle: bring down two sum bits, try 4r+1.
    assign rem_sh = {rem_reg[REM_BITS-3:0], sum_reg[SUM_BITS-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    assign dist_w    = CMP_BITS'(root_reg);
    assign limit_w   = CMP_BITS'(limit_reg);
    assign add_sum   = ADD_BITS'(total_reg) + ADD_BITS'(dist_w[LIMIT_BITS-1:0]);
    assign total_sat = (add_sum[ADD_BITS-1:TOTAL_BITS] != '0) ? {TOTAL_BITS{1'b1}}
                                                              : add_sum[TOTAL_BITS-1:0];

    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        limit_next     = limit_reg;
        have_last_next = have_last_reg;
        measure_next   = measure_reg;
        total_next     = total_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        last_z_next    = last_z_reg;
        mag_x_next     = mag_x_reg;
        mag_y_next     = mag_y_reg;
        mag_z_next     = mag_z_reg;
        mul_x_next     = mul_x_reg;
        mul_y_next     = mul_y_reg;
        mul_z_next     = mul_z_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        cnt_next       = cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (cfg_valid) begin
            case (cfg_index)
                REG_TRACKED_SLOT: slot_next  = cfg_wdata[SLOT_BITS-1:0];
                REG_JUMP_LIMIT:   limit_next = cfg_wdata[LIMIT_BITS-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    total_next     = total_eff;
                    have_last_next = hl_eff || counted;
                    measure_next   = counted && hl_eff;
                    if (counted) begin
                        last_x_next = in_x;
                        last_y_next = in_y;
                        last_z_next = in_z;
                    end
                    if (counted && hl_eff) begin
                        mag_x_next = abs_diff(in_x, last_x_reg);
                        mag_y_next = abs_diff(in_y, last_y_reg);
                        mag_z_next = abs_diff(in_z, last_z_reg);
                        mul_x_next = mag_x_next;
                        mul_y_next = mag_y_next;
                        mul_z_next = mag_z_next;
                        sum_next   = '0;
                        cnt_next   = CNT_BITS'(POS_BITS - 1);
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL: begin
                sum_next   = {acc[ACC_BITS-1:1], acc[0], sum_reg[POS_BITS-1:1]};
                mul_x_next = mul_x_reg >> 1;
                mul_y_next = mul_y_reg >> 1;
                mul_z_next = mul_z_reg >> 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = CNT_BITS'(ROOT_BITS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                sum_next = sum_reg << 2;
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = '0;
                    m_tdata_next  = M_DATA_BITS'(total_reg);
                    if (measure_reg) begin
                        if (dist_w < limit_w) begin
                            total_next               = total_sat;
                            m_tdata_next             = M_DATA_BITS'(total_sat);
                            m_tuser_next[USER_ADDED] = 1'b1;
                        end else begin
                            have_last_next          = 1'b0;
                            m_tuser_next[USER_JUMP] = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_reg      <= SLOT_RESET;
            limit_reg     <= LIMIT_RESET;
            have_last_reg <= 1'b0;
            measure_reg   <= 1'b0;
            total_reg     <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            limit_reg     <= limit_next;
            have_last_reg <= have_last_next;
            measure_reg   <= measure_next;
            total_reg     <= total_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            last_z_reg    <= last_z_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        mag_x_reg   <= mag_x_next;
        mag_y_reg   <= mag_y_next;
        mag_z_reg   <= mag_z_next;
        mul_x_reg   <= mul_x_next;
        mul_y_reg   <= mul_y_next;
        mul_z_reg   <= mul_z_next;
        sum_reg     <= sum_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    `ASSERT_NXT(a_mul_to_sqrt, aclk, aresetn, (state_reg == ST_MUL) && (cnt_reg == '0), state_reg == ST_SQRT)
    `ASSERT_IMP(a_rem_bound, aclk, aresetn, state_reg == ST_SQRT, rem_reg <= (REM_BITS'(root_reg) << 1))
    `ASSERT_NXT(a_done_holds, aclk, aresetn, (state_reg == ST_DONE) && m_tvalid_reg && !m_tready, state_reg == ST_DONE)

endmodule

@@ tb/path_length_odometer_checker.sv @@
// Checker for the path length odometer: follows the register writes, predicts each result and compares.
module path_length_odometer_checker
    import plo_pkg::*;
#(
    parameter int POS_W    = 24,
    parameter int TOTAL_W  = 40,
    parameter int S_DATA_W = 96,
    parameter int M_DATA_W = 40
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // owner, rate, pos_x, pos_y, pos_z from bit 0 up
    input  logic [S_DATA_W-1:0]       s_tdata,
    // restart
    input  logic                      s_tuser,

    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // total_distance from bit 0 up
    input  logic [M_DATA_W-1:0]       m_tdata,
    // added, jump_seen
    input  logic [M_USER_BITS-1:0]    m_tuser,

    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,

    output int                        outstanding,
    output int                        mismatches
);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               added;
        logic               jump_seen;
    } odo_result_t;

    logic [SLOT_BITS-1:0]    slot_reg;
    logic [LIMIT_BITS-1:0]   limit_reg;
    logic signed [POS_W-1:0] prev_x, prev_y, prev_z;
    logic                    have_start;
    logic [TOTAL_W-1:0]      path_sum;

    odo_result_t expected_totals[$];
    odo_result_t got_res, want_res;
    int          result_no;

    task automatic report_mismatch(input string what, input longint unsigned got_v,
                                   input longint unsigned want_v);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                     result_no, what, got_v, want_v);
        mismatches++;
    endtask

    function automatic longint unsigned axis_square(input logic signed [POS_W-1:0] a,
                                                    input logic signed [POS_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return longint'(d) * longint'(d);
    endfunction

    // Largest root whose square does not exceed the radicand, built from the top bit down.
    function automatic longint unsigned floor_root(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    function automatic odo_result_t step_odometer(input logic                    restart,
                                                  input logic [SLOT_BITS-1:0]    owner,
                                                  input logic [RATE_BITS-1:0]    rate,
                                                  input logic signed [POS_W-1:0] px,
                                                  input logic signed [POS_W-1:0] py,
                                                  input logic signed [POS_W-1:0] pz);
        odo_result_t     res;
        longint unsigned seg;
        res = '0;
        if (restart) begin
            path_sum   = '0;
            have_start = 1'b0;
        end
        if (owner == slot_reg && rate != 0) begin
            if (!have_start) begin
                have_start = 1'b1;
            end else begin
                seg = floor_root(axis_square(px, prev_x) + axis_square(py, prev_y)
                                 + axis_square(pz, prev_z));
                if (seg < limit_reg) begin
                    if (seg > TOTAL_MAX - path_sum)
                        path_sum = TOTAL_MAX;
                    else
                        path_sum = path_sum + TOTAL_W'(seg);
                    res.added = 1'b1;
                end else begin
                    // jump: next counted request starts a new path
                    have_start    = 1'b0;
                    res.jump_seen = 1'b1;
                end
            end
            prev_x = px;
            prev_y = py;
            prev_z = pz;
        end
        res.total = path_sum;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   = SLOT_RESET;
            limit_reg  = LIMIT_RESET;
            prev_x     = '0;
            prev_y     = '0;
            prev_z     = '0;
            have_start = 1'b0;
            path_sum   = '0;
            result_no  = 0;
            expected_totals.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TRACKED_SLOT: slot_reg = cfg_wdata[SLOT_BITS-1:0];
                    REG_JUMP_LIMIT:   limit_reg = cfg_wdata[LIMIT_BITS-1:0];
                    default: ;
                endcase
            end
            // compare before queuing, so a request accepted on this edge is not matched
            if (m_tvalid && m_tready) begin
                got_res.total     = m_tdata[TOTAL_W-1:0];
                got_res.added     = m_tuser[USER_ADDED];
                got_res.jump_seen = m_tuser[USER_JUMP];
                if (expected_totals.size() == 0) begin
                    report_mismatch("unexpected result, total_distance",
                                    64'(got_res.total), 64'd0);
                end else begin
                    want_res = expected_totals.pop_front();
                    if (got_res.total !== want_res.total)
                        report_mismatch("total_distance", 64'(got_res.total),
                                        64'(want_res.total));
                    if (got_res.added !== want_res.added)
                        report_mismatch("added", 64'(got_res.added), 64'(want_res.added));
                    if (got_res.jump_seen !== want_res.jump_seen)
                        report_mismatch("jump_seen", 64'(got_res.jump_seen),
                                        64'(want_res.jump_seen));
                end
                result_no++;
            end
            if (s_tvalid && s_tready)
                expected_totals.insert(expected_totals.size(), step_odometer(
                    s_tuser,
                    s_tdata[OWNER_LSB +: SLOT_BITS],
                    s_tdata[RATE_LSB +: RATE_BITS],
                    s_tdata[POS_LSB +: POS_W],
                    s_tdata[POS_LSB + POS_W +: POS_W],
                    s_tdata[POS_LSB + 2*POS_W +: POS_W]));
            outstanding <= expected_totals.size();
        end
    end

endmodule

@@ tb/tb_path_length_odometer.sv @@
// Testbench top for the path length odometer: clock, reset, requests, register writes and verdict.
module tb_path_length_odometer;
    import plo_pkg::*;

    localparam int POS_W          = 24;
    localparam int TOTAL_W        = 40;
    localparam int S_DATA_W       = ((SLOT_BITS + RATE_BITS + 3*POS_W + 7) / 8) * 8;
    localparam int M_DATA_W       = ((TOTAL_W + 7) / 8) * 8;
    localparam int MEASURE_CYCLES = 2*POS_W + 3;
    localparam int PHASE_ITEMS    = 105;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

    localparam logic [LIMIT_BITS-1:0]  LIMIT_TOP = '1;
    localparam logic signed [POS_W-1:0] POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_DATA_W-1:0]       s_tdata   = '0;
    logic                      s_tuser   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [M_DATA_W-1:0]       m_tdata;
    logic [M_USER_BITS-1:0]    m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    int outstanding;
    int mismatches;

    logic                    no_idle = 1'b0;
    int                      rx_hold = 0;
    logic [SLOT_BITS-1:0]    cur_slot = SLOT_RESET;
    logic signed [POS_W-1:0] walk_x = '0;
    logic signed [POS_W-1:0] walk_y = '0;
    logic signed [POS_W-1:0] walk_z = '0;

    path_length_odometer #(
        .POS_BITS   (POS_W),
        .TOTAL_BITS (TOTAL_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    path_length_odometer_checker #(
        .POS_W    (POS_W),
        .TOTAL_W  (TOTAL_W),
        .S_DATA_W (S_DATA_W),
        .M_DATA_W (M_DATA_W)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                rx_hold = pick_gap();
        end
    end

    // Leaves s_tvalid high after the handshake; the next call or settle() decides.
    task automatic send_sample(input logic                    restart,
                               input logic [SLOT_BITS-1:0]    owner,
                               input logic [RATE_BITS-1:0]    rate,
                               input logic signed [POS_W-1:0] x,
                               input logic signed [POS_W-1:0] y,
                               input logic signed [POS_W-1:0] z);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= S_DATA_W'({z, y, x, rate, owner});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid, drain every pending result, then let the datapath go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (MEASURE_CYCLES + 8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0]  value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_TRACKED_SLOT)
            cur_slot = value[SLOT_BITS-1:0];
    endtask

    function automatic int step_span();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 64;
        if (r < 8)
            return 8192;
        return 300000;
    endfunction

    // Mostly counted walks with small steps; the rest is noise.
    task automatic send_random();
        int                      pick;
        int                      span;
        logic [SLOT_BITS-1:0]    own;
        logic [RATE_BITS-1:0]    rt;
        logic signed [POS_W-1:0] nx, ny, nz;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            span = step_span();
            nx = walk_x + POS_W'($urandom_range(0, 2*span)) - POS_W'(span);
            ny = walk_y + POS_W'($urandom_range(0, 2*span)) - POS_W'(span);
            nz = walk_z + POS_W'($urandom_range(0, 2*span)) - POS_W'(span);
            send_sample($urandom_range(0, 39) == 0, cur_slot,
                        RATE_BITS'($urandom_range(1, 65535)), nx, ny, nz);
            walk_x = nx;
            walk_y = ny;
            walk_z = nz;
        end else if (pick < 85) begin
            own = SLOT_BITS'($urandom_range(0, 255));
            send_sample($urandom_range(0, 9) == 0, own,
                        RATE_BITS'($urandom()), walk_x, walk_y, walk_z);
        end else if (pick < 92) begin
            send_sample($urandom_range(0, 9) == 0, cur_slot, '0,
                        POS_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()));
        end else begin
            own = ($urandom_range(0, 1) == 0) ? cur_slot : SLOT_BITS'($urandom());
            rt  = RATE_BITS'($urandom());
            nx  = POS_W'($urandom());
            ny  = POS_W'($urandom());
            nz  = POS_W'($urandom());
            send_sample(1'($urandom_range(0, 1)), own, rt, nx, ny, nz);
            if (own == cur_slot && rt != 0) begin
                walk_x = nx;
                walk_y = ny;
                walk_z = nz;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: slot 0, limit 1000 m
        send_sample(1'b0, 8'h00, 16'h0001, POS_MIN, POS_MIN, POS_MIN);
        send_sample(1'b0, 8'h00, 16'hFFFF, POS_MAX, POS_MAX, POS_MAX);
        send_sample(1'b0, 8'h00, 16'h0001, POS_W'(0), POS_W'(0), POS_W'(0));
        send_sample(1'b0, 8'h00, 16'h0005, POS_W'(256), POS_W'(0), POS_W'(0));
        send_sample(1'b0, 8'h00, 16'h0005, POS_W'(256), POS_W'(0), POS_W'(0));
        send_sample(1'b0, 8'h00, 16'h0000, POS_W'(1000), POS_W'(0), POS_W'(0));
        send_sample(1'b0, 8'hFF, 16'hFFFF, POS_W'(1000), POS_W'(0), POS_W'(0));
        send_sample(1'b0, 8'h00, 16'h0007, POS_W'(256), POS_W'(768), POS_W'(-1024));
        // restart on a request that is not counted
        send_sample(1'b1, 8'h01, 16'h0003, POS_W'(0), POS_W'(0), POS_W'(0));
        send_sample(1'b0, 8'h00, 16'h0003, POS_W'(100), POS_W'(200), POS_W'(300));
        // segment exactly at the jump limit
        send_sample(1'b0, 8'h00, 16'h0003, POS_W'(100 + 256000), POS_W'(200), POS_W'(300));
        send_sample(1'b0, 8'h00, 16'h0003, POS_W'(0), POS_W'(0), POS_W'(0));
        send_sample(1'b0, 8'h00, 16'h0003, POS_W'(255999), POS_W'(0), POS_W'(0));
        send_sample(1'b1, 8'h00, 16'h0009, POS_W'(-5000), POS_W'(-5000), POS_W'(-5000));
        send_sample(1'b0, 8'h00, 16'h0009, POS_W'(-5768), POS_W'(-5000), POS_W'(-5000));

        settle();
        write_reg(REG_TRACKED_SLOT, CFG_DATA_BITS'(8'hFF));
        write_reg(REG_JUMP_LIMIT, LIMIT_TOP);
        write_reg(REG_SPARE_A, CFG_DATA_BITS'($urandom()));
        send_sample(1'b0, 8'hFF, 16'hFFFF, POS_MIN, POS_MAX, POS_MIN);
        send_sample(1'b0, 8'hFF, 16'h0001, POS_MAX, POS_MIN, POS_MAX);
        send_sample(1'b0, 8'h00, 16'h0001, POS_W'(0), POS_W'(0), POS_W'(0));

        // zero limit: every measured segment is a jump, even a zero-length one
        settle();
        write_reg(REG_JUMP_LIMIT, '0);
        write_reg(REG_SPARE_B, '1);
        send_sample(1'b0, 8'hFF, 16'h0001, POS_W'(12345), POS_W'(-6789), POS_W'(42));
        send_sample(1'b0, 8'hFF, 16'h0001, POS_W'(12345), POS_W'(-6789), POS_W'(42));
        send_sample(1'b0, 8'hFF, 16'h0001, POS_W'(12345), POS_W'(-6789), POS_W'(42));

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(REG_TRACKED_SLOT, CFG_DATA_BITS'(SLOT_RESET));
                    write_reg(REG_JUMP_LIMIT, LIMIT_RESET);
                end
                1: begin
                    write_reg(REG_TRACKED_SLOT, CFG_DATA_BITS'($urandom_range(0, 255)));
                    write_reg(REG_JUMP_LIMIT, CFG_DATA_BITS'($urandom()));
                    write_reg(REG_SPARE_A, CFG_DATA_BITS'($urandom()));
                end
                2: begin
                    write_reg(REG_TRACKED_SLOT, CFG_DATA_BITS'(8'hFF));
                    write_reg(REG_JUMP_LIMIT, LIMIT_TOP);
                end
                3: begin
                    write_reg(REG_TRACKED_SLOT, CFG_DATA_BITS'($urandom_range(0, 255)));
                    write_reg(REG_JUMP_LIMIT, CFG_DATA_BITS'($urandom_range(1, 2000)));
                    write_reg(REG_SPARE_B, CFG_DATA_BITS'($urandom()));
                end
                4: begin
                    write_reg(REG_TRACKED_SLOT, CFG_DATA_BITS'($urandom_range(0, 255)));
                    write_reg(REG_JUMP_LIMIT, '0);
                end
                default: begin
                    write_reg(REG_TRACKED_SLOT, CFG_DATA_BITS'($urandom_range(0, 255)));
                    write_reg(REG_JUMP_LIMIT, CFG_DATA_BITS'($urandom_range(100000, 400000)));
                end
            endcase
            // one phase runs back to back on both sides
            no_idle <= (ph == 2);
            @(posedge aclk);
            repeat (PHASE_ITEMS) send_random();
        end

        settle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/plo_pkg.sv
rtl/core/path_length_odometer.sv
tb/path_length_odometer_checker.sv
tb/tb_path_length_odometer.sv
